>>> rtl/mst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg
// Shared widths, event codes, flag positions and control structs of the
// multitouch slot tracker.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int SLOT_COUNT = 10;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int TYPE_W     = 5;
    localparam int CODE_W     = 10;
    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 2;
    localparam int SLOT_NUM_W = 4;
    localparam int COORD_W    = 16;
    localparam int FLAG_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // event types
    localparam logic [TYPE_W-1:0] EV_SYN = 5'd0;
    localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
    localparam logic [TYPE_W-1:0] EV_ABS = 5'd3;

    // event codes
    localparam logic [CODE_W-1:0] CODE_SYNC      = 10'h000;
    localparam logic [CODE_W-1:0] ABS_X          = 10'h000;
    localparam logic [CODE_W-1:0] ABS_Y          = 10'h001;
    localparam logic [CODE_W-1:0] CODE_MT_SEL    = 10'h02f;
    localparam logic [CODE_W-1:0] CODE_MT_X      = 10'h035;
    localparam logic [CODE_W-1:0] CODE_MT_Y      = 10'h036;
    localparam logic [CODE_W-1:0] CODE_MT_TRACK  = 10'h039;
    localparam logic [CODE_W-1:0] CODE_TOUCH_KEY = 10'h14a;

    localparam logic [VALUE_W-1:0] ID_NONE   = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] KEY_PRESS = 32'd1;
    localparam logic [VALUE_W-1:0] KEY_LIFT  = 32'd0;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd2;

    // flag bit positions
    localparam int FLAG_ACTIVE = 0;
    localparam int FLAG_POS    = 1;
    localparam int FLAG_DOWN   = 2;
    localparam int FLAG_UP     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MULTITOUCH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_SINGLE   = 2'd1;

    typedef struct packed {
        logic apply_event;
        logic scan_start;
        logic scan_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_sync;
        logic cur_emit;
        logic out_free;
        logic idx_last;
    } t_dp_status;

endpackage
`default_nettype wire

>>> rtl/mst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_if
// Valid/ready channels of the slot tracker: events in, touch results out,
// configuration writes.
// ----------------------------------------------------------------------------
interface mst_evt_if;
    logic                                 valid;
    logic                                 ready;
    logic [mst_pkg::TYPE_W-1:0]           event_type;
    logic [mst_pkg::CODE_W-1:0]           event_code;
    logic signed [mst_pkg::VALUE_W-1:0]   event_value;

    modport source (output valid, event_type, event_code, event_value, input ready);
    modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface mst_touch_if;
    logic                                 valid;
    logic                                 ready;
    logic [mst_pkg::KIND_W-1:0]           touch_kind;
    logic [mst_pkg::SLOT_NUM_W-1:0]       slot_number;
    logic signed [mst_pkg::VALUE_W-1:0]   contact_id;
    logic [mst_pkg::COORD_W-1:0]          pos_x;
    logic [mst_pkg::COORD_W-1:0]          pos_y;
    logic                                 last_of_frame;

    modport source (output valid, touch_kind, slot_number, contact_id, pos_x, pos_y,
                    last_of_frame, input ready);
    modport sink   (input valid, touch_kind, slot_number, contact_id, pos_x, pos_y,
                    last_of_frame, output ready);
endinterface

interface mst_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mst_pkg::CFG_IDX_W-1:0]        index;
    logic [mst_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/multitouch_slot_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multitouch_slot_tracker
// Keeps a table of finger slots from evdev-style events and reports down,
// up and move results for each sync report.
// ----------------------------------------------------------------------------
//  port      dir  beat
//  i_evt     in   event_type, event_code, event_value
//  o_touch   out  touch_kind, slot_number, contact_id, pos_x, pos_y, last_of_frame
//  i_cfg     in   index, data (0 multitouch_mode, 1 ignore_single)
//
//  A non-sync event is applied to the slot table when it is accepted. A sync
//  report is accepted, then the scan steps through every slot of the table
//  in order, stalling while a reporting slot waits on a full output register.
//  Synchronous reset restores the slot table and control registers.
//  Events are held off during a scan; a waiting result does not block events.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mst_evt_if.sink      i_evt,
    mst_touch_if.source  o_touch,
    mst_cfg_if.sink      i_cfg
);

    mst_pkg::t_ctrl_cmd   w_cmd;
    mst_pkg::t_dp_status  w_sts;
    logic                 w_in_ready;

    assign i_evt.ready = w_in_ready;

    mst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_event_type  (i_evt.event_type),
        .i_event_code  (i_evt.event_code),
        .i_event_value (i_evt.event_value),
        .i_cfg         (i_cfg),
        .o_touch       (o_touch)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_step && w_sts.cur_emit |-> w_sts.out_free)
        else $error("result stored over an undelivered beat");

    a_scan_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_start |=> !i_evt.ready)
        else $error("event beat taken during a scan");

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_step && w_sts.idx_last && w_sts.cur_emit
        |=> o_touch.valid && o_touch.last_of_frame)
        else $error("final slot result not marked last");

endmodule
`default_nettype wire

>>> rtl/mst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_ctrl
// Controller: takes event beats while idle and steps the slot scan of a sync
// report, one slot per cycle, stalling while a result cannot be stored.
// ----------------------------------------------------------------------------
module mst_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mst_pkg::t_dp_status   i_sts,
    output mst_pkg::t_ctrl_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.apply_event = i_in_valid && !i_sts.in_sync;
                o_cmd.scan_start  = i_in_valid && i_sts.in_sync;
                if (o_cmd.scan_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = !i_sts.cur_emit || i_sts.out_free;
                if (o_cmd.scan_step && i_sts.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/mst_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_dp
// Datapath: configuration registers, event decode, slot table, scan index
// and the result output register.
// ----------------------------------------------------------------------------
module mst_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mst_pkg::t_ctrl_cmd                  i_cmd,
    output mst_pkg::t_dp_status                 o_sts,
    input  logic [mst_pkg::TYPE_W-1:0]          i_event_type,
    input  logic [mst_pkg::CODE_W-1:0]          i_event_code,
    input  logic signed [mst_pkg::VALUE_W-1:0]  i_event_value,
    mst_cfg_if.sink                             i_cfg,
    mst_touch_if.source                         o_touch
);

    localparam int SC = mst_pkg::SLOT_COUNT;
    localparam int SW = mst_pkg::SLOT_W;

    logic                            r_mt_mode;
    logic                            r_ignore_single;
    logic [SW-1:0]                   r_sel;
    logic                            r_sel_valid;
    logic [SW-1:0]                   r_idx;

    logic [mst_pkg::FLAG_W-1:0]      r_flags [SC];
    logic [mst_pkg::VALUE_W-1:0]     r_id    [SC];
    logic [mst_pkg::COORD_W-1:0]     r_x     [SC];
    logic [mst_pkg::COORD_W-1:0]     r_y     [SC];
    logic [mst_pkg::FLAG_W-1:0]      n_flags [SC];
    logic [mst_pkg::VALUE_W-1:0]     n_id    [SC];
    logic [mst_pkg::COORD_W-1:0]     n_x     [SC];
    logic [mst_pkg::COORD_W-1:0]     n_y     [SC];

    logic                            r_out_valid;
    logic [mst_pkg::KIND_W-1:0]      r_out_kind;
    logic [mst_pkg::SLOT_NUM_W-1:0]  r_out_slot;
    logic [mst_pkg::VALUE_W-1:0]     r_out_id;
    logic [mst_pkg::COORD_W-1:0]     r_out_x;
    logic [mst_pkg::COORD_W-1:0]     r_out_y;
    logic                            r_out_last;

    logic [mst_pkg::VALUE_W-1:0]     w_val;
    logic [mst_pkg::COORD_W-1:0]     w_coord;
    logic                            w_ev_slot;
    logic                            w_ev_down;
    logic                            w_ev_up;
    logic                            w_ev_x;
    logic                            w_ev_y;
    logic [SW-1:0]                   w_tgt;
    logic [mst_pkg::VALUE_W-1:0]     w_new_id;
    logic [SC-1:0]                   w_emit;
    logic [SC-1:0]                   w_after;
    logic [mst_pkg::FLAG_W-1:0]      w_cur_flags;
    logic [mst_pkg::KIND_W-1:0]      w_kind;
    logic [mst_pkg::VALUE_W-1:0]     w_id;
    logic                            w_load;

    assign w_val = i_event_value;

    // clamp to 0..65535
    always_comb begin
        if (w_val[mst_pkg::VALUE_W-1]) begin
            w_coord = '0;
        end else if (|w_val[mst_pkg::VALUE_W-2:mst_pkg::COORD_W]) begin
            w_coord = '1;
        end else begin
            w_coord = w_val[mst_pkg::COORD_W-1:0];
        end
    end

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mt_mode       <= 1'b1;
            r_ignore_single <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mst_pkg::CFG_MULTITOUCH_MODE: r_mt_mode       <= i_cfg.data[0];
                mst_pkg::CFG_IGNORE_SINGLE:   r_ignore_single <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // event decode
    always_comb begin
        w_ev_slot = 1'b0;
        w_ev_down = 1'b0;
        w_ev_up   = 1'b0;
        w_ev_x    = 1'b0;
        w_ev_y    = 1'b0;
        w_tgt     = r_mt_mode ? r_sel : '0;
        w_new_id  = r_mt_mode ? w_val : '0;
        if (r_mt_mode) begin
            if (i_event_type == mst_pkg::EV_ABS) begin
                priority if (i_event_code == mst_pkg::CODE_MT_SEL) begin
                    w_ev_slot = 1'b1;
                end else if (i_event_code == mst_pkg::CODE_MT_TRACK && r_sel_valid) begin
                    w_ev_up   = (w_val == mst_pkg::ID_NONE);
                    w_ev_down = (w_val != mst_pkg::ID_NONE);
                end else if (i_event_code == mst_pkg::CODE_MT_X && r_sel_valid) begin
                    w_ev_x = 1'b1;
                end else if (i_event_code == mst_pkg::CODE_MT_Y && r_sel_valid) begin
                    w_ev_y = 1'b1;
                end else begin
                end
            end
        end else if (!r_ignore_single) begin
            if (i_event_type == mst_pkg::EV_ABS) begin
                w_ev_x = (i_event_code == mst_pkg::ABS_X);
                w_ev_y = (i_event_code == mst_pkg::ABS_Y);
            end else if (i_event_type == mst_pkg::EV_KEY
                         && i_event_code == mst_pkg::CODE_TOUCH_KEY) begin
                w_ev_down = (w_val == mst_pkg::KEY_PRESS);
                w_ev_up   = (w_val == mst_pkg::KEY_LIFT);
            end
        end
    end

    assign o_sts.in_sync = (i_event_type == mst_pkg::EV_SYN)
                        && (i_event_code == mst_pkg::CODE_SYNC)
                        && (r_mt_mode || !r_ignore_single);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= '0;
            r_sel_valid <= 1'b1;
        end else if (i_cmd.apply_event && w_ev_slot) begin
            if (w_val < mst_pkg::VALUE_W'(SC)) begin
                r_sel       <= w_val[SW-1:0];
                r_sel_valid <= 1'b1;
            end else begin
                r_sel_valid <= 1'b0;
            end
        end
    end

    // per-slot report flags
    always_comb begin
        for (int s = 0; s < SC; s++) begin
            w_emit[s]  = (r_flags[s][mst_pkg::FLAG_DOWN] && r_flags[s][mst_pkg::FLAG_POS])
                      || (r_flags[s][mst_pkg::FLAG_UP] && r_flags[s][mst_pkg::FLAG_ACTIVE])
                      || (r_flags[s][mst_pkg::FLAG_ACTIVE] && r_flags[s][mst_pkg::FLAG_POS]);
            w_after[s] = (SW'(s) > r_idx);
        end
    end

    assign w_cur_flags    = r_flags[r_idx];
    assign o_sts.cur_emit = w_emit[r_idx];
    assign o_sts.idx_last = (r_idx == SW'(SC - 1));
    assign o_sts.out_free = !r_out_valid || o_touch.ready;

    always_comb begin
        if (w_cur_flags[mst_pkg::FLAG_DOWN] && w_cur_flags[mst_pkg::FLAG_POS]) begin
            w_kind = mst_pkg::KIND_DOWN;
        end else if (w_cur_flags[mst_pkg::FLAG_UP]) begin
            w_kind = mst_pkg::KIND_UP;
        end else begin
            w_kind = mst_pkg::KIND_MOVE;
        end
        w_id = r_id[r_idx];
        if (w_kind == mst_pkg::KIND_UP && w_id == mst_pkg::ID_NONE) begin
            w_id = mst_pkg::VALUE_W'(r_idx);
        end
    end

    // slot table next state
    always_comb begin
        for (int s = 0; s < SC; s++) begin
            n_flags[s] = r_flags[s];
            n_id[s]    = r_id[s];
            n_x[s]     = r_x[s];
            n_y[s]     = r_y[s];
            if (i_cmd.apply_event && w_tgt == SW'(s)) begin
                if (w_ev_down) begin
                    n_id[s]                      = w_new_id;
                    n_flags[s][mst_pkg::FLAG_DOWN] = 1'b1;
                end
                if (w_ev_up) begin
                    n_flags[s][mst_pkg::FLAG_UP] = 1'b1;
                end
                if (w_ev_x) begin
                    n_x[s]                        = w_coord;
                    n_flags[s][mst_pkg::FLAG_POS] = 1'b1;
                end
                if (w_ev_y) begin
                    n_y[s]                        = w_coord;
                    n_flags[s][mst_pkg::FLAG_POS] = 1'b1;
                end
            end
            if (i_cmd.scan_step && r_idx == SW'(s)) begin
                if (r_flags[s][mst_pkg::FLAG_DOWN] && r_flags[s][mst_pkg::FLAG_POS]) begin
                    n_flags[s][mst_pkg::FLAG_ACTIVE] = 1'b1;
                    n_flags[s][mst_pkg::FLAG_DOWN]   = 1'b0;
                    n_flags[s][mst_pkg::FLAG_POS]    = 1'b0;
                end else if (r_flags[s][mst_pkg::FLAG_UP]) begin
                    if (r_flags[s][mst_pkg::FLAG_ACTIVE]) begin
                        n_flags[s][mst_pkg::FLAG_ACTIVE] = 1'b0;
                        n_id[s]                          = mst_pkg::ID_NONE;
                    end
                    n_flags[s][mst_pkg::FLAG_UP]  = 1'b0;
                    n_flags[s][mst_pkg::FLAG_POS] = 1'b0;
                end else if (r_flags[s][mst_pkg::FLAG_ACTIVE]
                             && r_flags[s][mst_pkg::FLAG_POS]) begin
                    n_flags[s][mst_pkg::FLAG_POS] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SC; s++) begin
                r_flags[s] <= '0;
                r_id[s]    <= mst_pkg::ID_NONE;
                r_x[s]     <= '0;
                r_y[s]     <= '0;
            end
        end else begin
            for (int s = 0; s < SC; s++) begin
                r_flags[s] <= n_flags[s];
                r_id[s]    <= n_id[s];
                r_x[s]     <= n_x[s];
                r_y[s]     <= n_y[s];
            end
        end
    end

    // scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= o_sts.idx_last ? '0 : r_idx + SW'(1);
        end
    end

    // output register
    assign w_load = i_cmd.scan_step && o_sts.cur_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_touch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_kind <= w_kind;
            r_out_slot <= mst_pkg::SLOT_NUM_W'(r_idx);
            r_out_id   <= w_id;
            r_out_x    <= r_x[r_idx];
            r_out_y    <= r_y[r_idx];
            r_out_last <= ~|(w_emit & w_after);
        end
    end

    assign o_touch.valid         = r_out_valid;
    assign o_touch.touch_kind    = r_out_kind;
    assign o_touch.slot_number   = r_out_slot;
    assign o_touch.contact_id    = r_out_id;
    assign o_touch.pos_x         = r_out_x;
    assign o_touch.pos_y         = r_out_y;
    assign o_touch.last_of_frame = r_out_last;

endmodule
`default_nettype wire
